@@ src/pfba_pkg.sv @@
package pfba_pkg;

  // Page geometry.
  localparam int unsigned PageBytes = 4096;
  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned Slots     = PageBytes / 4;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned StepW     = $clog2(Slots + 1);

  localparam logic [12:0] USABLE    = 13'(PageBytes - HdrBytes);
  localparam logic [11:0] HDR_OFF   = 12'(HdrBytes);
  localparam logic [13:0] PAGE_END  = 14'(PageBytes);
  localparam logic [StepW-1:0] STEP_LIMIT = StepW'(Slots);

  // Header memory word: next offset in the upper half, block size in the lower half.
  localparam int unsigned HdrW = 24;

  // Request kinds.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] STAT_ALLOC    = 3'd0;
  localparam logic [2:0] STAT_FRESH    = 3'd1;
  localparam logic [2:0] STAT_NO_FIT   = 3'd2;
  localparam logic [2:0] STAT_FREED    = 3'd3;
  localparam logic [2:0] STAT_RELEASED = 3'd4;
  localparam logic [2:0] STAT_REJECT   = 3'd5;

endpackage

@@ src/pfba_ram.sv @@
module pfba_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ src/page_free_block_allocator.sv @@
// Free-space manager for one 4096-byte page with a 12-byte page header.
// Requests arrive on the slave stream: tuser carries the kind (allocate or
// free), tdata carries the length and, for a free, the block offset. Every
// accepted word yields exactly one result word on the master stream: tuser
// carries the status, tdata the allocated offset and the free bytes left.
// Free blocks form an address-ordered list whose headers (next, size) live
// in a 1024 x 24 synchronous RAM indexed by offset / 4.
// One request is handled at a time. Rejects, fresh-page allocations, page
// releases and frees into an empty list go from accept straight to the
// result state, which loads the result register. A list walk does one RAM
// read per visited free block, and may add a second header write (ST_WR2)
// before the result state.
// Reset leaves the page inactive with an empty list; the RAM needs no
// clearing because a header is always written before it is read.
// A result waits in the output register while the receiver stalls; the
// next request is still accepted, and its result waits until the register
// has been emptied.
module page_free_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // length[11:0], offset[23:12]
  input  logic        s_axis_tuser_i,   // op[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // block_offset[11:0], avail_after[23:12]
  output logic [2:0]  m_axis_tuser_o    // status[2:0]
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AWALK = 3'd1;
  localparam logic [2:0] ST_FWALK = 3'd2;
  localparam logic [2:0] ST_WR2   = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        active_q, active_d;
  logic [11:0] head_q, head_d;
  logic [11:0] avail_q, avail_d;
  logic [12:0] need_q, need_d;
  logic [11:0] at_q, at_d;
  logic [11:0] cur_q, cur_d;
  logic [11:0] prev_q, prev_d;
  logic [11:0] psz_q, psz_d;
  logic [11:0] left_q, left_d;
  logic [pfba_pkg::StepW-1:0] steps_q, steps_d;
  logic [pfba_pkg::SlotW-1:0] w2_addr_q, w2_addr_d;
  logic [pfba_pkg::HdrW-1:0]  w2_data_q, w2_data_d;
  logic [2:0]  res_stat_q, res_stat_d;
  logic [11:0] res_off_q, res_off_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_stat_q, out_stat_d;
  logic [11:0] out_off_q, out_off_d;
  logic [11:0] out_avail_q, out_avail_d;

  logic                       ram_we;
  logic [pfba_pkg::SlotW-1:0] ram_waddr;
  logic [pfba_pkg::HdrW-1:0]  ram_wdata;
  logic                       ram_re;
  logic [pfba_pkg::SlotW-1:0] ram_raddr;
  logic [pfba_pkg::HdrW-1:0]  ram_rdata;

  // Request fields and derived sums.
  logic        in_op;
  logic [11:0] in_len;
  logic [11:0] in_off;
  logic [12:0] in_n;
  logic [13:0] free_end;
  logic [13:0] free_av;
  logic        accept;

  // Header of the block just read.
  logic [11:0] rd_next;
  logic [11:0] rd_size;

  // Walk helpers.
  logic [11:0] rest;
  logic [11:0] split;
  logic [11:0] link;
  logic [11:0] left_n;
  logic [11:0] n2;
  logic        back;
  logic        merge;
  logic [pfba_pkg::StepW-1:0] steps_n;

  assign in_op    = s_axis_tuser_i;
  assign in_len   = s_axis_tdata_i[11:0];
  assign in_off   = s_axis_tdata_i[23:12];
  assign in_n     = ({1'b0, in_len} + 13'd3) & ~13'd3;
  assign free_end = {2'b00, in_off} + {1'b0, in_n};
  assign free_av  = {2'b00, avail_q} + {1'b0, in_n};
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign rd_next  = ram_rdata[23:12];
  assign rd_size  = ram_rdata[11:0];
  assign steps_n  = steps_q + pfba_pkg::StepW'(1);

  pfba_ram #(
    .WIDTH(pfba_pkg::HdrW),
    .DEPTH(pfba_pkg::Slots)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Request sequencer: decode, list walk, header writes and result hand-off.
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    head_d      = head_q;
    avail_d     = avail_q;
    need_d      = need_q;
    at_d        = at_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    psz_d       = psz_q;
    left_d      = left_q;
    steps_d     = steps_q;
    w2_addr_d   = w2_addr_q;
    w2_data_d   = w2_data_q;
    res_stat_d  = res_stat_q;
    res_off_d   = res_off_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_stat_d  = out_stat_q;
    out_off_d   = out_off_q;
    out_avail_d = out_avail_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    rest        = rd_size - need_q[11:0];
    split       = cur_q + need_q[11:0];
    link        = (rest != 12'd0) ? split : rd_next;
    left_n      = (rd_size > left_q) ? 12'd0 : left_q - rd_size;
    merge       = ({2'b00, at_q} + {1'b0, need_q}) == {2'b00, cur_q};
    n2          = merge ? 12'(need_q + {1'b0, rd_size}) : need_q[11:0];
    back        = (prev_q != 12'd0) &&
                  (({1'b0, prev_q} + {1'b0, psz_q}) == {1'b0, at_q});

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          need_d    = in_n;
          at_d      = in_off;
          res_off_d = 12'd0;
          state_d   = ST_RESP;
          cur_d     = head_q;
          prev_d    = 12'd0;
          psz_d     = 12'd0;
          left_d    = avail_q;
          steps_d   = '0;
          if (in_op == pfba_pkg::OP_ALLOC) begin
            priority if (in_n == 13'd0 || in_n > pfba_pkg::USABLE) begin
              res_stat_d = pfba_pkg::STAT_REJECT;
            end else if (!active_q) begin
              active_d   = 1'b1;
              avail_d    = 12'(pfba_pkg::USABLE - in_n);
              res_stat_d = pfba_pkg::STAT_FRESH;
              res_off_d  = pfba_pkg::HDR_OFF;
              if (avail_d != 12'd0) begin
                head_d    = 12'({1'b0, pfba_pkg::HDR_OFF} + in_n);
                ram_we    = 1'b1;
                ram_waddr = head_d[11:2];
                ram_wdata = {12'd0, avail_d};
              end else begin
                head_d = 12'd0;
              end
            end else if ({1'b0, avail_q} < in_n) begin
              res_stat_d = pfba_pkg::STAT_NO_FIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q[11:2];
              state_d   = ST_AWALK;
            end
          end else begin
            priority if (!active_q || in_n == 13'd0 || in_off[1:0] != 2'd0 ||
                         in_off < pfba_pkg::HDR_OFF || free_end > pfba_pkg::PAGE_END ||
                         free_av > {1'b0, pfba_pkg::USABLE}) begin
              res_stat_d = pfba_pkg::STAT_REJECT;
            end else if (free_av == {1'b0, pfba_pkg::USABLE}) begin
              active_d   = 1'b0;
              avail_d    = 12'd0;
              head_d     = 12'd0;
              res_stat_d = pfba_pkg::STAT_RELEASED;
            end else if (head_q == 12'd0) begin
              ram_we     = 1'b1;
              ram_waddr  = in_off[11:2];
              ram_wdata  = {12'd0, in_n[11:0]};
              head_d     = in_off;
              avail_d    = free_av[11:0];
              res_stat_d = pfba_pkg::STAT_FREED;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q[11:2];
              state_d   = ST_FWALK;
            end
          end
        end
      end

      ST_AWALK: begin
        if ({1'b0, rd_size} >= need_q) begin
          // First fit: split off the tail and unlink the chosen block.
          if (rest != 12'd0) begin
            ram_we    = 1'b1;
            ram_waddr = split[11:2];
            ram_wdata = {rd_next, rest};
          end
          avail_d    = avail_q - need_q[11:0];
          res_stat_d = pfba_pkg::STAT_ALLOC;
          res_off_d  = cur_q;
          if (prev_q != 12'd0) begin
            w2_addr_d = prev_q[11:2];
            w2_data_d = {link, psz_q};
            state_d   = ST_WR2;
          end else begin
            head_d  = link;
            state_d = ST_RESP;
          end
        end else if ({1'b0, left_n} < need_q || steps_n == pfba_pkg::STEP_LIMIT) begin
          res_stat_d = pfba_pkg::STAT_NO_FIT;
          state_d    = ST_RESP;
        end else begin
          left_d    = left_n;
          prev_d    = cur_q;
          psz_d     = rd_size;
          cur_d     = rd_next;
          steps_d   = steps_n;
          ram_re    = 1'b1;
          ram_raddr = rd_next[11:2];
        end
      end

      ST_FWALK: begin
        if (steps_q < pfba_pkg::STEP_LIMIT && cur_q < at_q && rd_next != 12'd0) begin
          prev_d    = cur_q;
          psz_d     = rd_size;
          cur_d     = rd_next;
          steps_d   = steps_n;
          ram_re    = 1'b1;
          ram_raddr = rd_next[11:2];
        end else if (cur_q == at_q) begin
          // The block is already free.
          res_stat_d = pfba_pkg::STAT_REJECT;
          state_d    = ST_RESP;
        end else begin
          avail_d    = 12'({1'b0, avail_q} + need_q);
          res_stat_d = pfba_pkg::STAT_FREED;
          state_d    = ST_RESP;
          if (at_q < cur_q) begin
            // Insert before the stop block, merging forward and backward.
            ram_we    = 1'b1;
            ram_waddr = at_q[11:2];
            ram_wdata = {(merge ? rd_next : cur_q), n2};
            if (back) begin
              w2_addr_d = prev_q[11:2];
              w2_data_d = {(merge ? rd_next : cur_q), 12'(psz_q + n2)};
              state_d   = ST_WR2;
            end else if (prev_q != 12'd0) begin
              w2_addr_d = prev_q[11:2];
              w2_data_d = {at_q, psz_q};
              state_d   = ST_WR2;
            end else begin
              head_d = at_q;
            end
          end else if (({1'b0, cur_q} + {1'b0, rd_size}) == {1'b0, at_q}) begin
            // Grow the last block backward-adjacent to the freed one.
            ram_we    = 1'b1;
            ram_waddr = cur_q[11:2];
            ram_wdata = {rd_next, 12'(rd_size + need_q[11:0])};
          end else begin
            // Append after the stop block.
            ram_we    = 1'b1;
            ram_waddr = cur_q[11:2];
            ram_wdata = {at_q, rd_size};
            w2_addr_d = at_q[11:2];
            w2_data_d = {rd_next, need_q[11:0]};
            state_d   = ST_WR2;
          end
        end
      end

      ST_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = w2_addr_q;
        ram_wdata = w2_data_q;
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_off_d   = res_off_q;
          out_avail_d = avail_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      head_q      <= 12'd0;
      avail_q     <= 12'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      head_q      <= head_d;
      avail_q     <= avail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    need_q      <= need_d;
    at_q        <= at_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    psz_q       <= psz_d;
    left_q      <= left_d;
    steps_q     <= steps_d;
    w2_addr_q   <= w2_addr_d;
    w2_data_q   <= w2_data_d;
    res_stat_q  <= res_stat_d;
    res_off_q   <= res_off_d;
    out_stat_q  <= out_stat_d;
    out_off_q   <= out_off_d;
    out_avail_q <= out_avail_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_avail_q, out_off_q};
  assign m_axis_tuser_o  = out_stat_q;

  // One request at a time: the input closes right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("request accepted while another is in progress");

  // An inactive page has no free list and no free bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (head_q == 12'd0 && avail_q == 12'd0))
    else $error("inactive page with list state");

  // List walks only run on an active page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AWALK || state_q == ST_FWALK) |-> active_q)
    else $error("list walk on inactive page");

  // A waiting result is not overwritten by the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(m_axis_tdata_o)))
    else $error("pending result lost");

endmodule
